// File: rtl/core/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

   localparam int ADDR_W   = 48;
   localparam int BYTES_W  = 32;
   localparam int STATUS_W = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_ZERO    = 2'd1;
   localparam status_type ST_FULL    = 2'd2;
   localparam status_type ST_OUTSIDE = 2'd3;

   typedef logic [2:0] ptr_op_type;

   localparam ptr_op_type PTR_HOLD  = 3'd0;
   localparam ptr_op_type PTR_ZERO  = 3'd1;
   localparam ptr_op_type PTR_INC   = 3'd2;
   localparam ptr_op_type PTR_START = 3'd3;
   localparam ptr_op_type PTR_QUOT  = 3'd4;

   typedef logic [1:0] wr_op_type;

   localparam wr_op_type WR_NONE = 2'd0;
   localparam wr_op_type WR_ZERO = 2'd1;
   localparam wr_op_type WR_MARK = 2'd2;

   typedef logic [1:0] res_op_type;

   localparam res_op_type RES_HOLD    = 2'd0;
   localparam res_op_type RES_FULL    = 2'd1;
   localparam res_op_type RES_OUTSIDE = 2'd2;
   localparam res_op_type RES_GRANT   = 2'd3;

   typedef struct packed {
      logic       capture;
      ptr_op_type ptr_op;
      wr_op_type  wr_op;
      logic       scan_init;
      logic       scan_step;
      logic       sub;
      logic       div_init;
      logic       div_step;
      res_op_type res_op;
      logic       left_load;
      logic       left_dec;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_free;
      logic req_zero;
      logic ptr_last;
      logic found;
      logic mark_last;
      logic outside;
      logic len_zero;
      logic left_last;
   } sts_type;

endpackage

// File: rtl/core/ffba_req_if.sv
`timescale 1ns / 1ps

interface ffba_req_if;
   logic                             valid;
   logic                             ready;
   logic                             mode;
   logic [ffba_pkg::BYTES_W-1:0]     request_bytes;
   logic [ffba_pkg::ADDR_W-1:0]      free_address;

   modport source (output valid, output mode, output request_bytes, output free_address,
                   input ready);
   modport sink (input valid, input mode, input request_bytes, input free_address,
                 output ready);
endinterface

// File: rtl/core/ffba_rsp_if.sv
`timescale 1ns / 1ps

interface ffba_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ffba_pkg::STATUS_W-1:0]    status;
   logic [ffba_pkg::ADDR_W-1:0]      granted_address;

   modport source (output valid, output status, output granted_address, input ready);
   modport sink (input valid, input status, input granted_address, output ready);
endinterface

// File: rtl/core/ffba_ctrl.sv
`timescale 1ns / 1ps

module ffba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ffba_pkg::sts_type sts,
   output ffba_pkg::cmd_type cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_MARK  = 4'd3;
   localparam logic [3:0] S_SUB   = 4'd4;
   localparam logic [3:0] S_CHK   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_READ  = 4'd7;
   localparam logic [3:0] S_LEN   = 4'd8;
   localparam logic [3:0] S_FREE  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_op = ffba_pkg::WR_ZERO;
            if (sts.ptr_last) begin
               cmd.ptr_op = ffba_pkg::PTR_ZERO;
               state_in   = S_IDLE;
            end else begin
               cmd.ptr_op = ffba_pkg::PTR_INC;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (sts.req_free) begin
                  state_in = S_SUB;
               end else if (sts.req_zero) begin
                  state_in = S_DONE;
               end else begin
                  cmd.scan_init = 1'b1;
                  cmd.ptr_op    = ffba_pkg::PTR_ZERO;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.found) begin
               cmd.res_op = ffba_pkg::RES_GRANT;
               cmd.ptr_op = ffba_pkg::PTR_START;
               state_in   = S_MARK;
            end else if (sts.ptr_last) begin
               cmd.res_op = ffba_pkg::RES_FULL;
               state_in   = S_DONE;
            end else begin
               cmd.ptr_op = ffba_pkg::PTR_INC;
            end
         end
         S_MARK: begin
            cmd.wr_op = ffba_pkg::WR_MARK;
            if (sts.mark_last) begin
               state_in = S_DONE;
            end else begin
               cmd.ptr_op = ffba_pkg::PTR_INC;
            end
         end
         S_SUB: begin
            cmd.sub  = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.outside) begin
               cmd.res_op = ffba_pkg::RES_OUTSIDE;
               state_in   = S_DONE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = S_READ;
         end
         S_READ: begin
            cmd.ptr_op = ffba_pkg::PTR_QUOT;
            state_in   = S_LEN;
         end
         S_LEN: begin
            if (sts.len_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.left_load = 1'b1;
               state_in      = S_FREE;
            end
         end
         S_FREE: begin
            cmd.wr_op    = ffba_pkg::WR_ZERO;
            cmd.left_dec = 1'b1;
            if (sts.left_last || sts.ptr_last) begin
               state_in = S_DONE;
            end else begin
               cmd.ptr_op = ffba_pkg::PTR_INC;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/ffba_datapath.sv
`timescale 1ns / 1ps

module ffba_datapath #(
   parameter int HEAP_BLOCK_COUNT = 1024,
   parameter int BLOCK_BYTES      = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_mode,
   input  logic [ffba_pkg::BYTES_W-1:0]        req_request_bytes,
   input  logic [ffba_pkg::ADDR_W-1:0]         req_free_address,
   input  logic                                csr_write_enable,
   input  logic [ffba_pkg::ADDR_W-1:0]         csr_write_data,
   input  ffba_pkg::cmd_type                   cmd,
   output ffba_pkg::sts_type                   sts,
   output ffba_pkg::status_type                rsp_status,
   output logic [ffba_pkg::ADDR_W-1:0]         rsp_granted_address
);

   localparam int    AW         = ffba_pkg::ADDR_W;
   localparam int    PW         = $clog2(HEAP_BLOCK_COUNT);
   localparam int    LW         = $clog2(HEAP_BLOCK_COUNT + 1);
   localparam int    WORD_W     = LW + 1;
   localparam longint HEAP_BYTES = longint'(HEAP_BLOCK_COUNT) * longint'(BLOCK_BYTES);
   localparam int    OFS_W      = $clog2(HEAP_BYTES);
   localparam int    CAP_W      = $clog2(HEAP_BYTES + 1);
   localparam int    SH         = OFS_W + $clog2(BLOCK_BYTES);
   localparam longint RECIP     = ((longint'(1) << SH) + longint'(BLOCK_BYTES) - 1)
                                  / longint'(BLOCK_BYTES);
   localparam int    RW         = $clog2(RECIP + 1);
   localparam int    PROD_W     = OFS_W + RW;
   localparam int    CMP_W      = (CAP_W > ffba_pkg::BYTES_W) ? CAP_W : ffba_pkg::BYTES_W;

   localparam logic [PW-1:0]   LAST_PTR  = PW'(HEAP_BLOCK_COUNT - 1);
   localparam logic [AW-1:0]   BB_ADDR   = AW'(BLOCK_BYTES);
   localparam logic [CAP_W-1:0] BB_CAP   = CAP_W'(BLOCK_BYTES);
   localparam logic [AW-1:0]   HEAP_END  = AW'(HEAP_BYTES);
   localparam logic [RW-1:0]   RECIP_V   = RW'(RECIP);

   logic [WORD_W-1:0] mem [HEAP_BLOCK_COUNT];
   logic [WORD_W-1:0] rd_word_ff;
   logic              wr_en;
   logic [WORD_W-1:0] wr_word;
   logic              rd_used;
   logic [LW-1:0]     rd_len;

   logic [PW-1:0]              ptr_ff,        ptr_in;
   logic [PW-1:0]              end_ff,        end_in;
   logic [PW-1:0]              start_ff,      start_in;
   logic [LW-1:0]              count_ff,      count_in;
   logic [CAP_W-1:0]           cap_ff,        cap_in;
   logic [ffba_pkg::BYTES_W-1:0] bytes_ff,    bytes_in;
   logic [AW-1:0]              faddr_ff,      faddr_in;
   logic [AW-1:0]              base_ff,       base_in;
   logic [AW-1:0]              cur_addr_ff,   cur_addr_in;
   logic [AW-1:0]              run_addr_ff,   run_addr_in;
   logic [AW:0]                diff_ff,       diff_in;
   logic [OFS_W-1:0]           rem_ff,        rem_in;
   logic [PW-1:0]              quot_ff,       quot_in;
   logic [LW-1:0]              left_ff,       left_in;
   ffba_pkg::status_type       res_status_ff, res_status_in;
   logic [AW-1:0]              res_addr_ff,   res_addr_in;
   ffba_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [AW-1:0]              rsp_addr_ff,   rsp_addr_in;

   logic [CAP_W-1:0]  cap_sum;
   logic [AW-1:0]     addr_step;
   logic [PROD_W-1:0] prod;
   logic              found;

   assign rd_used   = rd_word_ff[WORD_W-1];
   assign rd_len    = rd_word_ff[LW-1:0];
   assign cap_sum   = cap_ff + BB_CAP;
   assign addr_step = cur_addr_ff + BB_ADDR;
   assign found     = !rd_used && (CMP_W'(cap_sum) >= CMP_W'(bytes_ff));
   assign prod      = PROD_W'(rem_ff) * PROD_W'(RECIP_V);

   always_comb begin
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      bytes_in      = bytes_ff;
      faddr_in      = faddr_ff;
      base_in       = csr_write_enable ? csr_write_data : base_ff;
      cur_addr_in   = cur_addr_ff;
      run_addr_in   = run_addr_ff;
      diff_in       = diff_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      left_in       = left_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;

      case (cmd.ptr_op)
         ffba_pkg::PTR_ZERO:  ptr_in = '0;
         ffba_pkg::PTR_INC:   ptr_in = ptr_ff + PW'(1);
         ffba_pkg::PTR_START: ptr_in = start_ff;
         ffba_pkg::PTR_QUOT:  ptr_in = quot_ff;
         default:             ptr_in = ptr_ff;
      endcase

      if (cmd.capture) begin
         bytes_in      = req_request_bytes;
         faddr_in      = req_free_address;
         res_addr_in   = '0;
         res_status_in = (!req_mode && req_request_bytes == '0) ? ffba_pkg::ST_ZERO
                                                                : ffba_pkg::ST_OK;
      end

      if (cmd.scan_init) begin
         count_in    = '0;
         cap_in      = '0;
         start_in    = '0;
         cur_addr_in = base_ff;
         run_addr_in = base_ff;
      end

      if (cmd.scan_step) begin
         cur_addr_in = addr_step;
         if (rd_used) begin
            count_in    = '0;
            cap_in      = '0;
            start_in    = ptr_ff + PW'(1);
            run_addr_in = addr_step;
         end else begin
            count_in = count_ff + LW'(1);
            cap_in   = cap_sum;
         end
         if (found) begin
            end_in = ptr_ff;
         end
      end

      if (cmd.sub) begin
         diff_in = {1'b0, faddr_ff} - {1'b0, base_ff};
      end

      if (cmd.div_init) begin
         rem_in = diff_ff[OFS_W-1:0];
      end

      if (cmd.div_step) begin
         quot_in = PW'(prod >> SH);
      end

      if (cmd.left_load) begin
         left_in = rd_len;
      end else if (cmd.left_dec) begin
         left_in = left_ff - LW'(1);
      end

      case (cmd.res_op)
         ffba_pkg::RES_FULL: begin
            res_status_in = ffba_pkg::ST_FULL;
            res_addr_in   = '0;
         end
         ffba_pkg::RES_OUTSIDE: begin
            res_status_in = ffba_pkg::ST_OUTSIDE;
            res_addr_in   = '0;
         end
         ffba_pkg::RES_GRANT: begin
            res_status_in = ffba_pkg::ST_OK;
            res_addr_in   = run_addr_ff;
         end
         default: begin
            res_status_in = res_status_in;
         end
      endcase

      if (cmd.load_rsp) begin
         rsp_status_in = res_status_ff;
         rsp_addr_in   = res_addr_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_word = '0;
      case (cmd.wr_op)
         ffba_pkg::WR_ZERO: begin
            wr_en = 1'b1;
         end
         ffba_pkg::WR_MARK: begin
            wr_en   = 1'b1;
            wr_word = {1'b1, (ptr_ff == start_ff) ? count_ff : LW'(0)};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff] <= wr_word;
      end
      rd_word_ff <= mem[ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         base_ff <= '0;
      end else begin
         ptr_ff  <= ptr_in;
         base_ff <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff        <= end_in;
      start_ff      <= start_in;
      count_ff      <= count_in;
      cap_ff        <= cap_in;
      bytes_ff      <= bytes_in;
      faddr_ff      <= faddr_in;
      cur_addr_ff   <= cur_addr_in;
      run_addr_ff   <= run_addr_in;
      diff_ff       <= diff_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      left_ff       <= left_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign sts.req_free  = req_mode;
   assign sts.req_zero  = (req_request_bytes == '0);
   assign sts.ptr_last  = (ptr_ff == LAST_PTR);
   assign sts.found     = found;
   assign sts.mark_last = (ptr_ff == end_ff);
   assign sts.outside   = diff_ff[AW] || (diff_ff[AW-1:0] >= HEAP_END);
   assign sts.len_zero  = (rd_len == '0);
   assign sts.left_last = (left_ff == LW'(1));

   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;

endmodule

// File: rtl/core/first_fit_block_allocator.sv
// Port       Direction  Word
// req_bus    in         mode, request_bytes, free_address (valid/ready)
// rsp_bus    out        status, granted_address (valid/ready)
// csr_*      in         heap_base write (write enable, write data)
//
// Allocate: a scan of up to HEAP_BLOCK_COUNT blocks (one block per cycle through the
//   block RAM read port), then the run is marked block by block and the response loaded.
// Free: base subtract, range check, reciprocal-multiply block index, length read, run clear.
// After reset a clearing pass zeroes every word of the block RAM;
//   req_bus is not ready until it ends, csr writes are taken throughout.
// The response register lets the next request in while a response waits on rsp_bus.
`timescale 1ns / 1ps

module first_fit_block_allocator #(
   parameter int HEAP_BLOCK_COUNT = 1024,
   parameter int BLOCK_BYTES      = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [ffba_pkg::ADDR_W-1:0] csr_write_data,
   ffba_req_if.sink                    req_bus,
   ffba_rsp_if.source                  rsp_bus
);

   ffba_pkg::cmd_type cmd;
   ffba_pkg::sts_type sts;
   logic              req_ready;
   logic              rsp_valid;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffba_datapath #(
      .HEAP_BLOCK_COUNT (HEAP_BLOCK_COUNT),
      .BLOCK_BYTES      (BLOCK_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_bus.mode),
      .req_request_bytes   (req_bus.request_bytes),
      .req_free_address    (req_bus.free_address),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_status          (rsp_bus.status),
      .rsp_granted_address (rsp_bus.granted_address)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

`ifndef SYNTHESIS
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted twice in a row");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("response register overwritten");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op != ffba_pkg::WR_NONE) |-> !req_bus.ready)
      else $error("block RAM written while idle");

   a_found_marks: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && sts.found) |=> (cmd.wr_op == ffba_pkg::WR_MARK))
      else $error("found run not marked");
`endif

endmodule
